// ----- hw/rtl/pct_pkg.sv -----
package pct_pkg;

	// fixed-point format and derived widths
	localparam int FRAC_BITS = 16;
	localparam int W         = 32;
	localparam int ROOT_W    = (W + FRAC_BITS + 1) / 2;
	localparam int RAD_W     = 2 * ROOT_W;
	localparam int NUM_W     = W + FRAC_BITS;

	// queue sizes
	localparam int MID_AW    = 2;
	localparam int MID_DEPTH = 1 << MID_AW;
	localparam int OUT_AW    = 1;
	localparam int OUT_DEPTH = 1 << OUT_AW;

	// shape codes and attribute word layout
	localparam logic SHAPE_CIRCLE = 1'b0;
	localparam int   ATTR_LAYER_LO = 0;
	localparam int   ATTR_MASK_LO  = 8;
	localparam int   ATTR_ACTIVE   = 16;

	localparam logic signed [W-1:0] FIX_ONE = W'(64'd1 << FRAC_BITS);

	typedef struct packed {
		logic signed [31:0] a_pos_x;
		logic signed [31:0] a_pos_y;
		logic signed [31:0] b_pos_x;
		logic signed [31:0] b_pos_y;
		logic               a_shape;
		logic               b_shape;
		logic [30:0]        a_size_w;
		logic [30:0]        a_size_h;
		logic [30:0]        b_size_w;
		logic [30:0]        b_size_h;
		logic [16:0]        a_attrs;
		logic [16:0]        b_attrs;
	} in_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] penetration;
		logic signed [31:0] contact_x;
		logic signed [31:0] contact_y;
	} out_t;

	// per-pair data carried alongside the square root and divide pipes
	typedef struct packed {
		logic                hit;
		logic                circ;
		logic signed [W-1:0] dx;
		logic signed [W-1:0] dy;
		logic signed [W-1:0] radii;
		logic signed [W-1:0] ax;
		logic signed [W-1:0] ay;
		logic [30:0]         aw;
		logic signed [W-1:0] nx;
		logic signed [W-1:0] ny;
		logic signed [W-1:0] pen;
		logic signed [W-1:0] cx;
		logic signed [W-1:0] cy;
	} side_t;

	typedef struct packed {
		side_t               side;
		logic signed [W-1:0] dsq;
	} mid_t;

	// fixed-point product, floor shift, wrapped to 32 bits
	function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [2*W-1:0] p;
		p = a * b;
		return p[FRAC_BITS +: W];
	endfunction

endpackage

// ----- hw/rtl/pct_front.sv -----
module pct_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pct_pkg::in_t   item,
	output logic           full,
	input  logic           mid_pop,
	output logic           mid_empty,
	output pct_pkg::mid_t  mid_head
);

	localparam int W  = pct_pkg::W;
	localparam int AW = pct_pkg::MID_AW;

	// half of a wrapped sum, truncated toward zero
	function automatic logic signed [W-1:0] half_tz(input logic signed [W-1:0] s);
		logic signed [W-1:0] t;
		t = s + {{(W-1){1'b0}}, s[W-1]};
		return t >>> 1;
	endfunction

	logic                fe;
	logic                accept;
	logic signed [W-1:0] dx_c, dy_c, radii_c, hsum_c, adx_c, ady_c;
	logic                gate_c;

	// stage 1
	logic                v_s1, gate_s1, circ_s1;
	logic signed [W-1:0] dx_s1, dy_s1, radii_s1, ox_s1, oy_s1, ax_s1, ay_s1, cx_s1, cy_s1;
	logic [30:0]         aw_s1;

	// stage 2
	logic                v_s2, gate_s2;
	logic signed [W-1:0] dxx_s2, dyy_s2, rsq_s2;
	pct_pkg::side_t      side_s2;
	pct_pkg::side_t      side_c;

	logic signed [W-1:0] dsq_c;
	pct_pkg::mid_t       wr_c;
	logic                mid_push;

	pct_pkg::mid_t       mem_q [pct_pkg::MID_DEPTH];
	logic [AW-1:0]       wr_q, rd_q;
	logic [AW:0]         cnt_q;

	assign fe     = cnt_q != (AW+1)'(pct_pkg::MID_DEPTH);
	assign full   = !fe;
	assign accept = push && fe;

	// classify and difference
	always_comb begin
		dx_c    = item.b_pos_x - item.a_pos_x;
		dy_c    = item.b_pos_y - item.a_pos_y;
		radii_c = W'({1'b0, item.a_size_w}) + W'({1'b0, item.b_size_w});
		hsum_c  = W'({1'b0, item.a_size_h}) + W'({1'b0, item.b_size_h});
		adx_c   = dx_c[W-1] ? -dx_c : dx_c;
		ady_c   = dy_c[W-1] ? -dy_c : dy_c;
		gate_c  = item.a_attrs[pct_pkg::ATTR_ACTIVE] && item.b_attrs[pct_pkg::ATTR_ACTIVE]
			&& ((|(item.a_attrs[pct_pkg::ATTR_MASK_LO +: 8]
				& item.b_attrs[pct_pkg::ATTR_LAYER_LO +: 8]))
			|| (|(item.b_attrs[pct_pkg::ATTR_MASK_LO +: 8]
				& item.a_attrs[pct_pkg::ATTR_LAYER_LO +: 8])))
			&& (item.a_shape == item.b_shape);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (fe) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			dx_s1    <= dx_c;
			dy_s1    <= dy_c;
			radii_s1 <= radii_c;
			ox_s1    <= radii_c - adx_c;
			oy_s1    <= hsum_c - ady_c;
			gate_s1  <= gate_c;
			circ_s1  <= item.a_shape == pct_pkg::SHAPE_CIRCLE;
			ax_s1    <= item.a_pos_x;
			ay_s1    <= item.a_pos_y;
			aw_s1    <= item.a_size_w;
			cx_s1    <= half_tz(item.a_pos_x + item.b_pos_x);
			cy_s1    <= half_tz(item.a_pos_y + item.b_pos_y);
		end
	end

	// box decision, axis of least overlap
	always_comb begin
		side_c       = '0;
		side_c.circ  = circ_s1;
		side_c.dx    = dx_s1;
		side_c.dy    = dy_s1;
		side_c.radii = radii_s1;
		side_c.ax    = ax_s1;
		side_c.ay    = ay_s1;
		side_c.aw    = aw_s1;
		side_c.cx    = cx_s1;
		side_c.cy    = cy_s1;
		side_c.hit   = gate_s1 && (ox_s1 > 0) && (oy_s1 > 0);
		if (ox_s1 < oy_s1) begin
			side_c.pen = ox_s1;
			side_c.nx  = (dx_s1 > 0) ? pct_pkg::FIX_ONE : -pct_pkg::FIX_ONE;
		end else begin
			side_c.pen = oy_s1;
			side_c.ny  = (dy_s1 > 0) ? pct_pkg::FIX_ONE : -pct_pkg::FIX_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			dxx_s2  <= pct_pkg::fmul(dx_s1, dx_s1);
			dyy_s2  <= pct_pkg::fmul(dy_s1, dy_s1);
			rsq_s2  <= pct_pkg::fmul(radii_s1, radii_s1);
			gate_s2 <= gate_s1;
			side_s2 <= side_c;
		end
	end

	// circle decision on squared distance
	always_comb begin
		dsq_c   = dxx_s2 + dyy_s2;
		wr_c.side = side_s2;
		wr_c.dsq  = dsq_c;
		if (side_s2.circ)
			wr_c.side.hit = gate_s2 && (dsq_c < rsq_s2);
	end

	assign mid_push  = v_s2 && fe;
	assign mid_empty = cnt_q == '0;
	assign mid_head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (mid_push)
				wr_q <= wr_q + 1'b1;
			if (mid_pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(mid_push) - (AW+1)'(mid_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (mid_push)
			mem_q[wr_q] <= wr_c;
	end

endmodule

// ----- hw/rtl/pct_sqrt.sv -----
module pct_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [pct_pkg::RAD_W-1:0]   rad,
	input  pct_pkg::side_t              in_side,
	output logic                        out_valid,
	output logic [pct_pkg::ROOT_W-1:0]  root,
	output pct_pkg::side_t              out_side
);

	localparam int RT = pct_pkg::ROOT_W;
	localparam int RD = pct_pkg::RAD_W;
	localparam int RW = RT + 2;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [RT-1:0] root;
		logic [RD-1:0] rad;
	} sq_t;

	// one root bit per stage
	function automatic sq_t sq_step(input sq_t s);
		sq_t           n;
		logic [RW-1:0] rs;
		logic [RW-1:0] t;
		logic          ge;
		rs     = {s.rem[RW-3:0], s.rad[RD-1 -: 2]};
		t      = {s.root, 2'b01};
		ge     = rs >= t;
		n.rem  = ge ? rs - t : rs;
		n.root = {s.root[RT-2:0], ge};
		n.rad  = {s.rad[RD-3:0], 2'b00};
		return n;
	endfunction

	sq_t            st_q  [RT];
	pct_pkg::side_t sd_q  [RT];
	sq_t            nxt_c [RT];
	sq_t            init_c;
	logic [RT-1:0]  vld_q;

	always_comb begin
		init_c.rem  = '0;
		init_c.root = '0;
		init_c.rad  = rad;
		nxt_c[0]    = sq_step(init_c);
		for (int k = 1; k < RT; k++)
			nxt_c[k] = sq_step(st_q[k-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[RT-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_q[0] <= in_side;
			for (int k = 0; k < RT; k++)
				st_q[k] <= nxt_c[k];
			for (int k = 1; k < RT; k++)
				sd_q[k] <= sd_q[k-1];
		end
	end

	assign out_valid = vld_q[RT-1];
	assign root      = st_q[RT-1].root;
	assign out_side  = sd_q[RT-1];

endmodule

// ----- hw/rtl/pct_div.sv -----
module pct_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [pct_pkg::ROOT_W-1:0]        den,
	input  pct_pkg::side_t                    in_side,
	output logic                              out_valid,
	output logic signed [pct_pkg::W-1:0]      qx,
	output logic signed [pct_pkg::W-1:0]      qy,
	output logic [pct_pkg::ROOT_W-1:0]        out_den,
	output pct_pkg::side_t                    out_side
);

	localparam int W  = pct_pkg::W;
	localparam int RT = pct_pkg::ROOT_W;
	localparam int NW = pct_pkg::NUM_W;

	typedef struct packed {
		logic [RT-1:0] rem;
		logic [W-1:0]  q;
		logic [NW-1:0] num;
	} dv_t;

	// one quotient bit per stage, low word of the quotient kept
	function automatic dv_t dv_step(input dv_t s, input logic [RT-1:0] d);
		dv_t         n;
		logic [RT:0] rs;
		logic [RT:0] df;
		logic        ge;
		rs    = {s.rem, s.num[NW-1]};
		df    = rs - {1'b0, d};
		ge    = rs >= {1'b0, d};
		n.rem = ge ? df[RT-1:0] : rs[RT-1:0];
		n.q   = {s.q[W-2:0], ge};
		n.num = {s.num[NW-2:0], 1'b0};
		return n;
	endfunction

	function automatic dv_t dv_init(input logic signed [W-1:0] v);
		dv_t        n;
		logic [W-1:0] mag;
		mag   = v[W-1] ? -v : v;
		n.rem = '0;
		n.q   = '0;
		n.num = {mag, {pct_pkg::FRAC_BITS{1'b0}}};
		return n;
	endfunction

	dv_t            xs_q [NW];
	dv_t            ys_q [NW];
	logic [RT-1:0]  dn_q [NW];
	pct_pkg::side_t sd_q [NW];
	logic [NW-1:0]  vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[NW-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xs_q[0] <= dv_step(dv_init(in_side.dx), den);
			ys_q[0] <= dv_step(dv_init(in_side.dy), den);
			dn_q[0] <= den;
			sd_q[0] <= in_side;
			for (int k = 1; k < NW; k++) begin
				xs_q[k] <= dv_step(xs_q[k-1], dn_q[k-1]);
				ys_q[k] <= dv_step(ys_q[k-1], dn_q[k-1]);
				dn_q[k] <= dn_q[k-1];
				sd_q[k] <= sd_q[k-1];
			end
		end
	end

	// quotient takes the dividend's sign, divisor is never negative
	assign out_valid = vld_q[NW-1];
	assign out_side  = sd_q[NW-1];
	assign out_den   = dn_q[NW-1];
	assign qx = sd_q[NW-1].dx[W-1] ? -xs_q[NW-1].q : xs_q[NW-1].q;
	assign qy = sd_q[NW-1].dy[W-1] ? -ys_q[NW-1].q : ys_q[NW-1].q;

endmodule

// ----- hw/rtl/pct_back.sv -----
module pct_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           mid_empty,
	input  pct_pkg::mid_t  mid_head,
	output logic           mid_pop,
	output logic           res_valid,
	output pct_pkg::out_t  res
);

	localparam int W  = pct_pkg::W;
	localparam int RT = pct_pkg::ROOT_W;
	localparam int RD = pct_pkg::RAD_W;

	logic [RD-1:0]       rad_c;
	logic                sq_valid, dv_valid;
	logic [RT-1:0]       sq_root, dv_den;
	pct_pkg::side_t      sq_side, dv_side;
	logic signed [W-1:0] qx, qy;

	logic                zero_c;
	logic signed [W-1:0] nx_c, ny_c, pen_c, aws_c;

	logic                v_f1;
	pct_pkg::side_t      side_f1;
	logic signed [W-1:0] nx_f1, ny_f1, pen_f1, px_f1, py_f1;

	assign mid_pop = en && !mid_empty;

	// radicand is dist_sq scaled up, or zero when dist_sq is not positive
	assign rad_c = (mid_head.dsq > 0)
		? RD'({mid_head.dsq, {pct_pkg::FRAC_BITS{1'b0}}}) : '0;

	pct_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (!mid_empty),
		.rad       (rad_c),
		.in_side   (mid_head.side),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	pct_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.den       (sq_root),
		.in_side   (sq_side),
		.out_valid (dv_valid),
		.qx        (qx),
		.qy        (qy),
		.out_den   (dv_den),
		.out_side  (dv_side)
	);

	// zero distance falls back to normal +x
	always_comb begin
		zero_c = dv_den == '0;
		nx_c   = zero_c ? pct_pkg::FIX_ONE : qx;
		ny_c   = zero_c ? '0 : qy;
		pen_c  = zero_c ? dv_side.radii : dv_side.radii - W'(dv_den);
		aws_c  = W'({1'b0, dv_side.aw});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_f1 <= 1'b0;
		else if (en)
			v_f1 <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_f1 <= dv_side;
			nx_f1   <= nx_c;
			ny_f1   <= ny_c;
			pen_f1  <= pen_c;
			px_f1   <= pct_pkg::fmul(nx_c, aws_c);
			py_f1   <= pct_pkg::fmul(ny_c, aws_c);
		end
	end

	always_comb begin
		res = '0;
		if (side_f1.hit) begin
			res.hit = 1'b1;
			if (side_f1.circ) begin
				res.normal_x    = nx_f1;
				res.normal_y    = ny_f1;
				res.penetration = pen_f1;
				res.contact_x   = side_f1.ax + px_f1;
				res.contact_y   = side_f1.ay + py_f1;
			end else begin
				res.normal_x    = side_f1.nx;
				res.normal_y    = side_f1.ny;
				res.penetration = side_f1.pen;
				res.contact_x   = side_f1.cx;
				res.contact_y   = side_f1.cy;
			end
		end
	end

	assign res_valid = v_f1;

endmodule

// ----- hw/rtl/pair_collision_test_unit.sv -----
// channel   direction  word                handshake
// item      in         pct_pkg::in_t       push / full, taken when push && !full
// result    out        pct_pkg::out_t      empty / pop, taken when pop && !empty
//
// one pair per cycle sustained while neither queue is full; a pair's result passes
// through the square root pipe (one root bit per stage, 24 stages) and
// the divide pipe (one quotient bit per stage, 48 stages) at 16 fraction bits
// front (2 stages) feeds a 4-word queue; the back pipe stalls as a whole while
// the 2-word result queue is full, and the front stalls while its queue is full
// arst_n clears every valid bit, pointer and count; no clearing pass is needed
module pair_collision_test_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  pct_pkg::in_t  item,
	output logic          empty,
	input  logic          pop,
	output pct_pkg::out_t result
);

	localparam int OAW = pct_pkg::OUT_AW;

	// front to back queue
	logic          mid_pop, mid_empty;
	pct_pkg::mid_t mid_head;

	// back pipe result
	logic          bk_en, bk_valid;
	pct_pkg::out_t bk_res;

	// result queue
	pct_pkg::out_t out_q [pct_pkg::OUT_DEPTH];
	logic [OAW-1:0] owr_q, ord_q;
	logic [OAW:0]   ocnt_q;
	logic           opush, opop;

	pct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.mid_pop   (mid_pop),
		.mid_empty (mid_empty),
		.mid_head  (mid_head)
	);

	pct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (bk_en),
		.mid_empty (mid_empty),
		.mid_head  (mid_head),
		.mid_pop   (mid_pop),
		.res_valid (bk_valid),
		.res       (bk_res)
	);

	// back pipe only moves while the result queue has a free word
	assign bk_en  = ocnt_q != (OAW+1)'(pct_pkg::OUT_DEPTH);
	assign opush  = bk_valid && bk_en;
	assign opop   = pop && !empty;
	assign empty  = ocnt_q == '0;
	assign result = out_q[ord_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (opush)
				owr_q <= owr_q + 1'b1;
			if (opop)
				ord_q <= ord_q + 1'b1;
			ocnt_q <= ocnt_q + (OAW+1)'(opush) - (OAW+1)'(opop);
		end
	end

	always_ff @(posedge clk) begin
		if (opush)
			out_q[owr_q] <= bk_res;
	end

`ifndef SYNTHESIS
	a_ocnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= (OAW+1)'(pct_pkg::OUT_DEPTH))
		else $error("result queue count above depth");

	a_ocnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ocnt_q == (OAW+1)'($past(ocnt_q) + (OAW+1)'($past(opush))
			- (OAW+1)'($past(opop))))
		else $error("result queue count lost a word");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.hit) |-> (result.normal_x == 0 && result.normal_y == 0
			&& result.penetration == 0 && result.contact_x == 0
			&& result.contact_y == 0))
		else $error("miss word carries nonzero fields");
`endif

endmodule
